// ===== rtl/core/bf2d_pkg.sv =====
// Shared types and constants for the 2x2 box-filter downsampler.
package bf2d_pkg;

    localparam int COMP_W       = 8;
    localparam int SUM_W        = COMP_W + 1;
    localparam int NUM_COMP     = 4;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 2;
    localparam int ROW_W        = 12;
    localparam int HEIGHT_LIMIT = 4096;
    localparam int MAX_WIDTH    = 4096;

    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 13'd256;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 13'd256;
    localparam logic                  FOUR_RESET   = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_COMPONENTS = 2'd2;

    typedef logic [NUM_COMP-1:0][COMP_W-1:0] pixel_t;
    typedef logic [NUM_COMP-1:0][SUM_W-1:0]  pair_sum_t;

endpackage

// ===== rtl/core/box_filter_2x2_downsample.sv =====
// Top level of the 2x2 box-filter downsampler.
// A block's right pixel on an odd row is registered in stage 1, then in the output register.
// Throughput: one source pixel per cycle while in_ready is high; the line store takes one
// write or one read per pixel. Output stalls back up through a single staging register.
// Reset clears counters, config (256, 256, four components) and the left pixel. The line store
// is not cleared; the user must write each entry on an even row before it is read (unchecked).
module box_filter_2x2_downsample #(
    parameter int MAX_WIDTH = bf2d_pkg::MAX_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [bf2d_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bf2d_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [bf2d_pkg::COMP_W-1:0]         comp_a,
    input  logic [bf2d_pkg::COMP_W-1:0]         comp_b,
    input  logic [bf2d_pkg::COMP_W-1:0]         comp_c,
    input  logic [bf2d_pkg::COMP_W-1:0]         comp_d,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [bf2d_pkg::COMP_W-1:0]         avg_a,
    output logic [bf2d_pkg::COMP_W-1:0]         avg_b,
    output logic [bf2d_pkg::COMP_W-1:0]         avg_c,
    output logic [bf2d_pkg::COMP_W-1:0]         avg_d,
    output logic                                last_pixel
);

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int EW    = (COLW + 1 > bf2d_pkg::CFG_DATA_W) ? COLW + 1 : bf2d_pkg::CFG_DATA_W;
    localparam int HW    = bf2d_pkg::CFG_DATA_W;
    localparam int RW    = bf2d_pkg::ROW_W;

    // configuration
    logic [bf2d_pkg::CFG_DATA_W-1:0] source_width_reg;
    logic [bf2d_pkg::CFG_DATA_W-1:0] source_height_reg;
    logic                            four_components_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg    <= bf2d_pkg::WIDTH_RESET;
            source_height_reg   <= bf2d_pkg::HEIGHT_RESET;
            four_components_reg <= bf2d_pkg::FOUR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bf2d_pkg::CFG_SOURCE_WIDTH:    source_width_reg    <= cfg_data;
                bf2d_pkg::CFG_SOURCE_HEIGHT:   source_height_reg   <= cfg_data;
                bf2d_pkg::CFG_FOUR_COMPONENTS: four_components_reg <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    // effective sizes
    logic [EW-1:0] width_ext;
    logic [EW-1:0] eff_w;
    logic [EW-1:0] out_w;
    logic [HW-1:0] eff_h;
    logic [HW-1:0] out_h;

    always_comb
    begin
        width_ext = EW'(source_width_reg);
        if (width_ext == '0)
            eff_w = EW'(1);
        else if (width_ext > EW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = width_ext;
        if (source_height_reg == '0)
            eff_h = HW'(1);
        else if (source_height_reg > HW'(bf2d_pkg::HEIGHT_LIMIT))
            eff_h = HW'(bf2d_pkg::HEIGHT_LIMIT);
        else
            eff_h = source_height_reg;
        out_w = eff_w >> 1;
        out_h = eff_h >> 1;
    end

    // position counters and left pixel
    logic [COLW-1:0]     col_reg;
    logic [COLW-1:0]     col_next;
    logic [RW-1:0]       row_reg;
    logic [RW-1:0]       row_next;
    bf2d_pkg::pixel_t    left_reg;
    bf2d_pkg::pixel_t    left_next;
    bf2d_pkg::pixel_t    pix;
    bf2d_pkg::pair_sum_t pair_sum;

    logic [COLW:0]     col_inc;
    logic [RW:0]       row_inc;
    logic [COLW-2:0]   half_col;
    logic [RW-2:0]     half_row;
    logic              in_accept;
    logic              col_in_range;
    logic              mem_wr;
    logic              emit;
    logic              emit_last;

    assign in_accept = in_valid && in_ready;
    assign half_col  = col_reg[COLW-1:1];
    assign half_row  = row_reg[RW-1:1];

    always_comb
    begin
        pix[0] = comp_a;
        pix[1] = comp_b;
        pix[2] = comp_c;
        pix[3] = four_components_reg ? comp_d : '0;
        for (int k = 0; k < bf2d_pkg::NUM_COMP; k++)
        begin
            pair_sum[k] = bf2d_pkg::SUM_W'(left_reg[k]) + bf2d_pkg::SUM_W'(pix[k]);
        end
    end

    always_comb
    begin
        col_in_range = col_reg[0] && (EW'(half_col) < out_w);
        mem_wr       = in_accept && col_in_range && !row_reg[0];
        emit         = col_in_range && row_reg[0] && (HW'(half_row) < out_h);
        emit_last    = (EW'(half_col) == out_w - EW'(1)) && (HW'(half_row) == out_h - HW'(1));

        left_next = left_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        col_inc   = {1'b0, col_reg} + (COLW + 1)'(1);
        row_inc   = {1'b0, row_reg} + (RW + 1)'(1);
        if (in_accept)
        begin
            if (!col_reg[0])
                left_next = pix;
            if (EW'(col_inc) >= eff_w)
            begin
                col_next = '0;
                if (HW'(row_inc) >= eff_h)
                    row_next = '0;
                else
                    row_next = row_inc[RW-1:0];
            end
            else
            begin
                col_next = col_inc[COLW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= left_next;
        end
    end

    // line store
    bf2d_pkg::pair_sum_t above;

    bf2d_line_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_mem (
        .clk     (clk),
        .wr_en   (mem_wr),
        .wr_addr (AW'(half_col)),
        .wr_data (pair_sum),
        .rd_en   (in_accept && emit),
        .rd_addr (AW'(half_col)),
        .rd_data (above)
    );

    // stage 1: waits for the line store read
    logic                s1_valid_reg;
    logic                s1_valid_next;
    bf2d_pkg::pair_sum_t s1_sum_reg;
    logic                s1_last_reg;
    logic                s1_advance;

    logic                out_valid_reg;
    logic                out_valid_next;
    bf2d_pkg::pixel_t    avg_reg;
    bf2d_pkg::pixel_t    avg_next;
    logic                last_reg;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || !out_valid_reg || out_ready;

    always_comb
    begin
        if (in_accept && emit)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (s1_advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        for (int k = 0; k < bf2d_pkg::NUM_COMP; k++)
        begin
            avg_next[k] = 8'(((bf2d_pkg::SUM_W + 1)'(above[k])
                             + (bf2d_pkg::SUM_W + 1)'(s1_sum_reg[k])) >> 2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && emit)
        begin
            s1_sum_reg  <= pair_sum;
            s1_last_reg <= emit_last;
        end
        if (s1_advance)
        begin
            avg_reg  <= avg_next;
            last_reg <= s1_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign avg_a      = avg_reg[0];
    assign avg_b      = avg_reg[1];
    assign avg_c      = avg_reg[2];
    assign avg_d      = avg_reg[3];
    assign last_pixel = last_reg;

endmodule

// ===== rtl/core/bf2d_line_mem.sv =====
// Line store of pair sums: one write port, one registered read port.
module bf2d_line_mem #(
    parameter int DEPTH = bf2d_pkg::MAX_WIDTH / 2,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  bf2d_pkg::pair_sum_t wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output bf2d_pkg::pair_sum_t rd_data
);

    bf2d_pkg::pair_sum_t mem [DEPTH];
    bf2d_pkg::pair_sum_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bf2d_checker.sv =====
// Port-level checks for the 2x2 box-filter downsampler, bound to the top level.
module bf2d_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [bf2d_pkg::COMP_W-1:0] avg_a,
    input logic [bf2d_pkg::COMP_W-1:0] avg_b,
    input logic [bf2d_pkg::COMP_W-1:0] avg_c,
    input logic [bf2d_pkg::COMP_W-1:0] avg_d,
    input logic                        last_pixel
);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable({avg_a, avg_b, avg_c, avg_d, last_pixel}))
        else $error("result changed while stalled");

    // input side backs up only behind a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("in_ready low without output stall");

    a_reset_idle: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && in_ready)
        else $error("not idle after reset");

endmodule

bind box_filter_2x2_downsample bf2d_checker u_bf2d_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the 2x2 box-filter downsampler.
`timescale 1ns / 1ps

module tb_top;

    import bf2d_pkg::*;

    localparam int LINE_DEPTH   = MAX_WIDTH / 2;
    localparam int RANDOM_ITEMS = 250;
    localparam int QUIET_LIMIT  = 2000;
    localparam int STALL_CYCLES = 400;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic {ROW_PIXEL, ROW_CONFIG} row_kind_e;

    typedef struct packed {
        pixel_t avg;
        logic   last;
    } block_avg_t;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  value;
        pixel_t                 px;
        logic                   typed;
        block_avg_t             want;
    } script_row_t;

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   cfg_wr_en  = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index  = '0;
    logic [CFG_DATA_W-1:0]  cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic                   in_ready;
    logic [COMP_W-1:0]      comp_a     = '0;
    logic [COMP_W-1:0]      comp_b     = '0;
    logic [COMP_W-1:0]      comp_c     = '0;
    logic [COMP_W-1:0]      comp_d     = '0;
    logic                   out_valid;
    logic                   out_ready  = 1'b0;
    logic [COMP_W-1:0]      avg_a;
    logic [COMP_W-1:0]      avg_b;
    logic [COMP_W-1:0]      avg_c;
    logic [COMP_W-1:0]      avg_d;
    logic                   last_pixel;

    // predictor state
    logic [CFG_DATA_W-1:0] width_reg  = WIDTH_RESET;
    logic [CFG_DATA_W-1:0] height_reg = HEIGHT_RESET;
    logic                  four_reg   = FOUR_RESET;
    pair_sum_t             pair_line [LINE_DEPTH];
    bit                    pair_written [LINE_DEPTH];
    pixel_t                left_px    = '0;
    int unsigned           col_cnt    = 0;
    int unsigned           row_cnt    = 0;

    block_avg_t  expected_averages [$];
    script_row_t directed_rows [$];
    string       avg_names [NUM_COMP] = '{"avg_a", "avg_b", "avg_c", "avg_d"};

    int error_count  = 0;
    int quiet_cycles = 0;
    bit steady       = 1'b0;
    int hold_asked   = 0;
    int hold_served  = 0;
    int hold_left    = 0;

    box_filter_2x2_downsample DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .comp_a     (comp_a),
        .comp_b     (comp_b),
        .comp_c     (comp_c),
        .comp_d     (comp_d),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .avg_a      (avg_a),
        .avg_b      (avg_b),
        .avg_c      (avg_c),
        .avg_d      (avg_d),
        .last_pixel (last_pixel)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
        if (v < 1)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advances the predicted state by one source pixel; returns 1 when a block completes.
    function automatic bit downsample_pixel(input pixel_t px, output block_avg_t avg);
        int unsigned eff_w;
        int unsigned eff_h;
        int unsigned out_w;
        int unsigned out_h;
        int unsigned hc;
        int unsigned hr;
        pixel_t      cur;
        pair_sum_t   ps;
        logic [SUM_W:0] total;
        bit          hit;
        eff_w = eff_size(width_reg, MAX_WIDTH);
        eff_h = eff_size(height_reg, HEIGHT_LIMIT);
        out_w = eff_w / 2;
        out_h = eff_h / 2;
        hc    = col_cnt / 2;
        hr    = row_cnt / 2;
        cur   = px;
        if (!four_reg)
            cur[3] = '0;
        hit = 1'b0;
        avg = '0;
        if (col_cnt % 2 == 0)
            left_px = cur;
        else if (hc < out_w && hc < LINE_DEPTH)
        begin
            for (int k = 0; k < NUM_COMP; k++)
                ps[k] = {1'b0, left_px[k]} + {1'b0, cur[k]};
            if (row_cnt % 2 == 0)
            begin
                pair_line[hc]    = ps;
                pair_written[hc] = 1'b1;
            end
            else if (hr < out_h)
            begin
                for (int k = 0; k < NUM_COMP; k++)
                begin
                    total      = {1'b0, pair_line[hc][k]} + {1'b0, ps[k]};
                    avg.avg[k] = total[SUM_W:2];
                end
                avg.last = (hc == out_w - 1) && (hr == out_h - 1);
                hit = 1'b1;
            end
        end
        col_cnt++;
        if (col_cnt >= eff_w)
        begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= eff_h)
                row_cnt = 0;
        end
        return hit;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        for (int k = 0; k < NUM_COMP; k++)
        begin
            case ($urandom_range(15))
                0:       px[k] = 8'd0;
                1:       px[k] = 8'd255;
                default: px[k] = 8'($urandom_range(255));
            endcase
        end
        return px;
    endfunction

    function automatic script_row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
        script_row_t r;
        r       = '0;
        r.kind  = ROW_CONFIG;
        r.idx   = idx;
        r.value = value;
        return r;
    endfunction

    function automatic script_row_t px_row(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c, input logic [7:0] d);
        script_row_t r;
        r      = '0;
        r.kind = ROW_PIXEL;
        r.px   = {d, c, b, a};
        return r;
    endfunction

    function automatic script_row_t px_check(input logic [7:0] a, input logic [7:0] b,
                                             input logic [7:0] c, input logic [7:0] d,
                                             input logic [7:0] ea, input logic [7:0] eb,
                                             input logic [7:0] ec, input logic [7:0] ed,
                                             input logic elast);
        script_row_t r;
        r           = px_row(a, b, c, d);
        r.typed     = 1'b1;
        r.want.avg  = {ed, ec, eb, ea};
        r.want.last = elast;
        return r;
    endfunction

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_SOURCE_WIDTH:    width_reg  = value;
            CFG_SOURCE_HEIGHT:   height_reg = value;
            CFG_FOUR_COMPONENTS: four_reg   = value[0];
            default: ;
        endcase
    endtask

    task automatic push_pixel(input pixel_t px, input bit typed, input block_avg_t typed_want);
        block_avg_t avg;
        bit         hit;
        @(negedge clk);
        if (!steady && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < 37);
        end
        in_valid <= 1'b1;
        comp_a   <= px[0];
        comp_b   <= px[1];
        comp_c   <= px[2];
        comp_d   <= px[3];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hit = downsample_pixel(px, avg);
        if (hit)
            expected_averages.insert(expected_averages.size(), typed ? typed_want : avg);
    endtask

    // drain the pipeline before touching configuration
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_averages.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            hold_left   = STALL_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(99) >= 37);
    end

    always @(posedge clk)
    begin : result_check
        block_avg_t seen;
        block_avg_t want;
        if (rst_n && out_valid && out_ready)
        begin
            seen.avg  = {avg_d, avg_c, avg_b, avg_a};
            seen.last = last_pixel;
            if (expected_averages.size() == 0)
            begin
                $error("result transaction with no pending expectation");
                error_count++;
            end
            else
            begin
                want = expected_averages.pop_front();
                for (int k = 0; k < NUM_COMP; k++)
                begin
                    if (seen.avg[k] !== want.avg[k])
                    begin
                        $error("%s: expected %0d, got %0d", avg_names[k], want.avg[k],
                               seen.avg[k]);
                        error_count++;
                    end
                end
                if (seen.last !== want.last)
                begin
                    $error("last_pixel: expected %0d, got %0d", want.last, seen.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int unsigned new_w;
        int unsigned new_h;
        int          n;
        int          random_items;
        bit          safe;
        directed_rows = '{
            cfg_row(CFG_SOURCE_WIDTH, 13'd2),
            cfg_row(CFG_SOURCE_HEIGHT, 13'd2),
            px_row(8'd255, 8'd255, 8'd255, 8'd255),
            px_row(8'd255, 8'd255, 8'd255, 8'd255),
            px_row(8'd255, 8'd255, 8'd255, 8'd255),
            px_check(8'd255, 8'd255, 8'd255, 8'd255,
                     8'd255, 8'd255, 8'd255, 8'd255, 1'b1),
            px_row(8'd0, 8'd0, 8'd0, 8'd0),
            px_row(8'd0, 8'd0, 8'd0, 8'd0),
            px_row(8'd0, 8'd0, 8'd0, 8'd0),
            px_check(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1),
            px_row(8'd255, 8'd0, 8'd128, 8'd1),
            px_row(8'd255, 8'd0, 8'd127, 8'd2),
            px_row(8'd255, 8'd0, 8'd128, 8'd3),
            px_check(8'd254, 8'd3, 8'd127, 8'd4, 8'd254, 8'd0, 8'd127, 8'd2, 1'b1),
            cfg_row(CFG_FOUR_COMPONENTS, 13'd0),
            px_row(8'd255, 8'd255, 8'd255, 8'd255),
            px_row(8'd255, 8'd255, 8'd255, 8'd255),
            px_row(8'd255, 8'd255, 8'd255, 8'd255),
            px_check(8'd255, 8'd255, 8'd255, 8'd255,
                     8'd255, 8'd255, 8'd255, 8'd0, 1'b1),
            cfg_row(CFG_UNUSED, 13'h1FFF),
            cfg_row(CFG_SOURCE_WIDTH, 13'd3),
            cfg_row(CFG_SOURCE_HEIGHT, 13'd3),
            cfg_row(CFG_FOUR_COMPONENTS, 13'd1),
            px_row(8'h12, 8'hA5, 8'hFF, 8'h80),
            px_row(8'h34, 8'h5A, 8'h01, 8'h7F),
            px_row(8'hEE, 8'hEE, 8'hEE, 8'hEE),
            px_row(8'h56, 8'hC3, 8'hFE, 8'h40),
            px_row(8'h78, 8'h3C, 8'h02, 8'hBF),
            px_row(8'hDD, 8'hDD, 8'hDD, 8'hDD),
            px_row(8'h11, 8'h22, 8'h33, 8'h44),
            px_row(8'h55, 8'h66, 8'h77, 8'h88),
            px_row(8'h99, 8'hAA, 8'hBB, 8'hCC)
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CONFIG)
            begin
                settle();
                write_register(directed_rows[r].idx, directed_rows[r].value);
            end
            else
                push_pixel(directed_rows[r].px, directed_rows[r].typed, directed_rows[r].want);
        end

        // two full rows at full rate on both sides
        settle();
        write_register(CFG_SOURCE_WIDTH, 13'd64);
        write_register(CFG_SOURCE_HEIGHT, 13'd2);
        steady = 1'b1;
        repeat (128) push_pixel(random_pixel(), 1'b0, '0);
        steady = 1'b0;

        // tallest image, saturated; long output stall while input keeps coming
        settle();
        write_register(CFG_SOURCE_WIDTH, 13'd2);
        write_register(CFG_SOURCE_HEIGHT, 13'h1FFF);
        write_register(CFG_FOUR_COMPONENTS, 13'd0);
        hold_asked++;
        repeat (150) push_pixel(random_pixel(), 1'b0, '0);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(9))
                0:       new_w = $urandom_range(1);
                1:       new_w = $urandom_range(13, 64);
                default: new_w = $urandom_range(2, 12);
            endcase
            case ($urandom_range(9))
                0:       new_h = $urandom_range(1);
                1:       new_h = $urandom_range(10, 20);
                default: new_h = $urandom_range(2, 9);
            endcase
            // growing the width on an odd row must not reach unwritten line entries
            if (row_cnt % 2 == 1)
            begin
                safe = 1'b1;
                for (int i = 0; i < eff_size(new_w, MAX_WIDTH) / 2 && i < LINE_DEPTH; i++)
                    if (!pair_written[i])
                        safe = 1'b0;
                if (!safe)
                    new_w = width_reg;
            end
            if ($urandom_range(9) < 7)
                write_register(CFG_SOURCE_WIDTH, CFG_DATA_W'(new_w));
            if ($urandom_range(9) < 7)
                write_register(CFG_SOURCE_HEIGHT, CFG_DATA_W'(new_h));
            if ($urandom_range(9) < 7)
                write_register(CFG_FOUR_COMPONENTS, CFG_DATA_W'($urandom_range(1)));
            if (eff_size(width_reg, MAX_WIDTH) < 2 || eff_size(height_reg, HEIGHT_LIMIT) < 2)
                n = $urandom_range(1, 20);
            else
            begin
                if ($urandom_range(3) != 0)
                    n = eff_size(width_reg, MAX_WIDTH) * eff_size(height_reg, HEIGHT_LIMIT)
                        * $urandom_range(1, 2);
                else
                    n = $urandom_range(1, 3 * eff_size(width_reg, MAX_WIDTH));
                if (n > 120)
                    n = 120;
                random_items += n;
            end
            repeat (n) push_pixel(random_pixel(), 1'b0, '0);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_averages.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
